[rtl/rtt_pkg.sv]
// Package: shared types and constants of the retransmission tracking table.
`default_nettype none

package rtt_pkg;

    // Table geometry and limits
    localparam int QUEUE_DEPTH      = 8;
    localparam int SLOT_W           = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_PACKET_BYTES = 1024;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam logic [7:0] RETRY_LIMIT_RESET = 8'd3;

    // Operation codes
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_ACK  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // Result kinds
    localparam logic [2:0] KIND_ADD    = 3'd0;
    localparam logic [2:0] KIND_ACK    = 3'd1;
    localparam logic [2:0] KIND_RETX   = 3'd2;
    localparam logic [2:0] KIND_GIVEUP = 3'd3;
    localparam logic [2:0] KIND_DONE   = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  segment_number;
        logic [10:0] packet_length;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        accepted;
        logic [2:0]  slot;
        logic [7:0]  entry_segment;
        logic [10:0] entry_length;
        logic [7:0]  attempt_number;
        logic [3:0]  pending_count;
        logic        last;
    } result_t;

    // Head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        logic oversize;
        cmd_t word;
    } qhead_t;

endpackage

`default_nettype wire

[rtl/retransmission_tracking_table_core.sv]
// Top level: retransmission tracking table with command queue and sequencer.
`default_nettype none

// Tracks up to eight packets awaiting acknowledgement (payload kept outside,
// addressed by slot).
// Command channel: a word on cmd is taken at a clock edge with start high and
// busy low. Operation add takes the lowest free slot, ack clears every
// pending entry of that segment, tick walks the slots for retransmission.
// Unused operation code: taken, but produces nothing.
// Result channel: result_valid marks a result word for exactly one cycle;
// the receiver cannot stall, so no back-pressure exists on this side.
// Result path: an add or ack word waits in the queue until the idle sequencer
// pops it; its result word is then registered. Throughput: add and ack sustain
// one word per cycle while no tick holds the sequencer; a tick holds it for its
// start, a one-slot-per-cycle scan and its done word. A two-word queue in front
// lets new commands in while the scan runs; busy is high while that queue is full.
// Configuration: cfg_wr_en/cfg_wr_data write retry_limit, only while idle: a user rule the block does not enforce.
// Reset (rst_n, async, active low): all entries free, count zero, retry
// limit 3, queue empty; no clearing pass is needed.
module retransmission_tracking_table_core
    import rtt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire cmd_t       cmd,
    output logic            busy,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    output result_t         result,
    output logic            result_valid
);

    qhead_t head;   // oldest queued command word
    logic   pop;    // sequencer takes the head

    rtt_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .pop   (pop),
        .head  (head)
    );

    rtt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .head         (head),
        .pop          (pop),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

`default_nettype wire

[rtl/rtt_front.sv]
// Front end: takes command words, drops unused codes, queues the rest.
`default_nettype none

module rtt_front
    import rtt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   start,
    input  wire cmd_t   cmd,
    output logic        busy,
    input  wire logic   pop,
    output qhead_t      head
);

    cmd_t                  q_word_reg [CMDQ_DEPTH];
    logic                  q_over_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] cnt_reg, cnt_next;

    logic take;
    logic push;
    logic do_pop;

    assign busy   = (cnt_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign take   = start && !busy;
    // unused code causes nothing, so it never enters the queue
    assign push   = take && (cmd.operation != OP_NONE);
    assign do_pop = pop && (cnt_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                          : wr_ptr_reg + CMDQ_PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                          : rd_ptr_reg + CMDQ_PTR_W'(1);
        end
        case ({push, do_pop})
            2'b10:   cnt_next = cnt_reg + CMDQ_CNT_W'(1);
            2'b01:   cnt_next = cnt_reg - CMDQ_CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_word_reg[wr_ptr_reg] <= cmd;
            q_over_reg[wr_ptr_reg] <= (cmd.packet_length > 11'(MAX_PACKET_BYTES));
        end
    end

    assign head.valid    = (cnt_reg != '0);
    assign head.oversize = q_over_reg[rd_ptr_reg];
    assign head.word     = q_word_reg[rd_ptr_reg];

endmodule

`default_nettype wire

[rtl/rtt_back.sv]
// Back end: entry table, retry register and the add/ack/tick sequencer.
`default_nettype none

module rtt_back
    import rtt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire qhead_t head,
    output logic        pop,
    output result_t     result,
    output logic        result_valid
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [QUEUE_DEPTH-1:0] pend_reg, pend_next;
    logic [7:0]          seg_reg   [QUEUE_DEPTH];
    logic [7:0]          retr_reg  [QUEUE_DEPTH];
    logic [10:0]         len_reg   [QUEUE_DEPTH];
    logic [COUNT_W-1:0]  total_reg, total_next;
    logic [7:0]          limit_reg;
    result_t             res_reg, res_next;
    logic                res_valid_reg, res_valid_next;

    // table writes
    logic                wr_add;
    logic                wr_dec;
    logic                free_found;
    logic [SLOT_W-1:0]   free_idx;
    logic [QUEUE_DEPTH-1:0] match;
    logic                match_any;
    logic [SLOT_W-1:0]   match_first;
    logic [COUNT_W-1:0]  match_cnt;
    logic [7:0]          retr_dec;
    logic [COUNT_W-1:0]  total_inc;
    logic [COUNT_W-1:0]  total_dec;

    // lowest free slot, ack matches
    always_comb
    begin
        free_found  = 1'b0;
        free_idx    = '0;
        match_any   = 1'b0;
        match_first = '0;
        match_cnt   = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!pend_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
            match[i] = pend_reg[i] && (seg_reg[i] == head.word.segment_number);
            if (match[i])
            begin
                match_any   = 1'b1;
                match_first = SLOT_W'(i);
            end
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            match_cnt = match_cnt + COUNT_W'(match[i]);
        end
    end

    assign retr_dec  = retr_reg[idx_reg] - 8'd1;
    assign total_inc = total_reg + COUNT_W'(1);
    assign total_dec = total_reg - COUNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        total_next     = total_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;
        pop            = 1'b0;
        wr_add         = 1'b0;
        wr_dec         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    res_valid_next = 1'b1;
                    res_next = '0;
                    res_next.entry_segment = head.word.segment_number;
                    res_next.last          = 1'b1;
                    res_next.pending_count = 4'(total_reg);
                    unique case (head.word.operation)
                        OP_ADD:
                        begin
                            res_next.kind = KIND_ADD;
                            if (!head.oversize && free_found)
                            begin
                                wr_add                 = 1'b1;
                                pend_next[free_idx]    = 1'b1;
                                total_next             = total_inc;
                                res_next.accepted      = 1'b1;
                                res_next.slot          = 3'(free_idx);
                                res_next.entry_length  = head.word.packet_length;
                                res_next.pending_count = 4'(total_inc);
                            end
                        end
                        OP_ACK:
                        begin
                            pend_next              = pend_reg & ~match;
                            total_next             = total_reg - match_cnt;
                            res_next.kind          = KIND_ACK;
                            res_next.accepted      = match_any;
                            res_next.slot          = 3'(match_first);
                            res_next.pending_count = 4'(total_reg - match_cnt);
                        end
                        default:
                        begin
                            // timeout tick: result words come from the scan
                            res_valid_next = 1'b0;
                            idx_next       = '0;
                            state_next     = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (pend_reg[idx_reg])
                begin
                    res_valid_next         = 1'b1;
                    res_next               = '0;
                    res_next.slot          = 3'(idx_reg);
                    res_next.entry_segment = seg_reg[idx_reg];
                    res_next.pending_count = 4'(total_reg);
                    if (retr_reg[idx_reg] != 8'd0)
                    begin
                        wr_dec                  = 1'b1;
                        res_next.kind           = KIND_RETX;
                        res_next.entry_length   = len_reg[idx_reg];
                        res_next.attempt_number = limit_reg - retr_dec;
                    end
                    else
                    begin
                        pend_next[idx_reg]     = 1'b0;
                        total_next             = total_dec;
                        res_next.kind          = KIND_GIVEUP;
                        res_next.pending_count = 4'(total_dec);
                    end
                end
                if (idx_reg == SLOT_W'(QUEUE_DEPTH - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_DONE:
            begin
                res_valid_next         = 1'b1;
                res_next               = '0;
                res_next.kind          = KIND_DONE;
                res_next.pending_count = 4'(total_reg);
                res_next.last          = 1'b1;
                state_next             = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            pend_reg      <= '0;
            total_reg     <= '0;
            limit_reg     <= RETRY_LIMIT_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // entry payload; contents of a free entry are never read out
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (wr_add)
        begin
            seg_reg[free_idx]  <= head.word.segment_number;
            retr_reg[free_idx] <= limit_reg;
            len_reg[free_idx]  <= head.word.packet_length;
        end
        if (wr_dec)
        begin
            retr_reg[idx_reg] <= retr_dec;
        end
    end

    assign result       = res_reg;
    assign result_valid = res_valid_reg;

endmodule

`default_nettype wire

[rtl/rtt_checker.sv]
// Checker: port-level properties of the table core, with its bind.
`default_nettype none

module rtt_checker
    import rtt_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire result_t    result,
    input wire logic       result_valid
);

    // tick-done always closes the input; scan words never do
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == KIND_DONE) |-> result.last)
        else $error("tick done word without last");

    a_scan_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == KIND_RETX || result.kind == KIND_GIVEUP)
        |-> !result.last && !result.accepted)
        else $error("scan word marked last or accepted");

    // back-to-back scan words walk the slots upwards
    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && $past(result_valid)
        && (result.kind == KIND_RETX || result.kind == KIND_GIVEUP)
        && ($past(result.kind) == KIND_RETX || $past(result.kind) == KIND_GIVEUP)
        |-> result.slot > $past(result.slot))
        else $error("scan slot order broken");

    // a give-up releases exactly one entry against the previous scan word
    a_giveup_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && $past(result_valid) && (result.kind == KIND_GIVEUP)
        && ($past(result.kind) == KIND_RETX || $past(result.kind) == KIND_GIVEUP)
        |-> result.pending_count == $past(result.pending_count) - 4'd1)
        else $error("give-up count step wrong");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.pending_count <= 4'(QUEUE_DEPTH))
        else $error("pending count out of range");

endmodule

bind retransmission_tracking_table_core rtt_checker u_rtt_checker (.*);

`default_nettype wire

[sim/retransmission_tracking_table_core_tb.sv]
// Testbench: retransmission tracking table core checked word by word against a shadow table.
module retransmission_tracking_table_core_tb;
    import rtt_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 7;
    // Quiet time before a retry limit write: a full scan plus two queued words
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_WORDS   = 44;

    typedef struct {
        logic       is_cfg;
        logic [7:0] cfg_val;
        cmd_t       word;
        logic       typed;
        result_t    want;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    cmd_t       cmd_word;
    logic       busy;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;
    result_t    res_word;
    logic       res_valid;

    // Typed expectation travelling alongside the command word
    logic       cur_typed;
    result_t    cur_want;

    // Shadow copy of the table
    logic        shadow_pending [QUEUE_DEPTH];
    logic [7:0]  shadow_seg     [QUEUE_DEPTH];
    logic [7:0]  shadow_left    [QUEUE_DEPTH];
    logic [10:0] shadow_len     [QUEUE_DEPTH];
    logic [3:0]  shadow_total;
    logic [7:0]  shadow_limit;

    result_t   due_results [$];
    result_t   step_results [$];
    stim_row_t directed_rows [$];

    int err_count;
    int cycle_count;
    int burst_left;
    int n_words;
    int n_refused;
    int n_ticks;
    int n_retx;
    int n_giveup;
    int n_checked;
    logic [7:0] mid_limit;

    retransmission_tracking_table_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd_word),
        .busy         (busy),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result       (res_word),
        .result_valid (res_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words still due", cycle_count,
                     due_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic cmd_t mk_cmd(logic [1:0] op, logic [7:0] seg, logic [10:0] len);
        cmd_t c;
        c.operation      = op;
        c.segment_number = seg;
        c.packet_length  = len;
        return c;
    endfunction

    function automatic result_t mk_res(logic [2:0] kind, logic acc, int slot, logic [7:0] seg,
                                       logic [10:0] len, logic [7:0] att, logic [3:0] pend,
                                       logic last);
        result_t r;
        r.kind           = kind;
        r.accepted       = acc;
        r.slot           = slot[2:0];
        r.entry_segment  = seg;
        r.entry_length   = len;
        r.attempt_number = att;
        r.pending_count  = pend;
        r.last           = last;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    task automatic shadow_reset();
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            shadow_pending[i] = 1'b0;
            shadow_seg[i]     = '0;
            shadow_left[i]    = '0;
            shadow_len[i]     = '0;
        end
        shadow_total = '0;
        shadow_limit = RETRY_LIMIT_RESET;
    endtask

    // Freed slot: contents zeroed, counter reloaded from the current limit
    task automatic shadow_free(input int i);
        shadow_pending[i] = 1'b0;
        shadow_seg[i]     = '0;
        shadow_left[i]    = shadow_limit;
        shadow_len[i]     = '0;
        if (shadow_total != 0)
            shadow_total = shadow_total - 4'd1;
    endtask

    // Works out the result words of one command word and updates the shadow table
    task automatic table_step(input cmd_t w);
        int found;
        logic [7:0] seg_was;
        logic [7:0] att;
        found = -1;
        case (w.operation)
            OP_ADD:
            begin
                if (w.packet_length <= MAX_PACKET_BYTES)
                begin
                    for (int i = 0; i < QUEUE_DEPTH; i++)
                    begin
                        if (!shadow_pending[i] && found < 0)
                            found = i;
                    end
                end
                if (found >= 0)
                begin
                    shadow_pending[found] = 1'b1;
                    shadow_seg[found]     = w.segment_number;
                    shadow_left[found]    = shadow_limit;
                    shadow_len[found]     = w.packet_length;
                    shadow_total          = shadow_total + 4'd1;
                    step_results.push_back(mk_res(KIND_ADD, 1'b1, found, w.segment_number,
                                                  w.packet_length, 8'd0, shadow_total, 1'b1));
                end
                else
                begin
                    n_refused++;
                    step_results.push_back(mk_res(KIND_ADD, 1'b0, 0, w.segment_number,
                                                  11'd0, 8'd0, shadow_total, 1'b1));
                end
            end
            OP_ACK:
            begin
                for (int i = 0; i < QUEUE_DEPTH; i++)
                begin
                    if (shadow_pending[i] && shadow_seg[i] == w.segment_number)
                    begin
                        if (found < 0)
                            found = i;
                        shadow_free(i);
                    end
                end
                step_results.push_back(mk_res(KIND_ACK, found >= 0, (found >= 0) ? found : 0,
                                              w.segment_number, 11'd0, 8'd0, shadow_total,
                                              1'b1));
            end
            OP_TICK:
            begin
                n_ticks++;
                for (int i = 0; i < QUEUE_DEPTH; i++)
                begin
                    if (shadow_pending[i])
                    begin
                        if (shadow_left[i] != 0)
                        begin
                            shadow_left[i] = shadow_left[i] - 8'd1;
                            att = shadow_limit - shadow_left[i];   // wraps mod 256
                            n_retx++;
                            step_results.push_back(mk_res(KIND_RETX, 1'b0, i, shadow_seg[i],
                                                          shadow_len[i], att, shadow_total,
                                                          1'b0));
                        end
                        else
                        begin
                            seg_was = shadow_seg[i];
                            shadow_free(i);
                            n_giveup++;
                            step_results.push_back(mk_res(KIND_GIVEUP, 1'b0, i, seg_was, 11'd0,
                                                          8'd0, shadow_total, 1'b0));
                        end
                    end
                end
                step_results.push_back(mk_res(KIND_DONE, 1'b0, 0, 8'd0, 11'd0, 8'd0,
                                              shadow_total, 1'b1));
            end
            default: ;   // unused code: no word back
        endcase
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        string d;
        if (due_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result word %h", got));
        end
        else
        begin
            want = due_results.pop_front();
            n_checked++;
            d = "";
            if (got.kind !== want.kind)                     d = {d, " kind"};
            if (got.accepted !== want.accepted)             d = {d, " accepted"};
            if (got.slot !== want.slot)                     d = {d, " slot"};
            if (got.entry_segment !== want.entry_segment)   d = {d, " entry_segment"};
            if (got.entry_length !== want.entry_length)     d = {d, " entry_length"};
            if (got.attempt_number !== want.attempt_number) d = {d, " attempt_number"};
            if (got.pending_count !== want.pending_count)   d = {d, " pending_count"};
            if (got.last !== want.last)                     d = {d, " last"};
            if (d != "")
                report_mismatch($sformatf("fields%s differ: got %h want %h", d, got, want));
        end
    endtask

    // Observer: all sampling on the rising edge, before the block's own updates land
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                shadow_limit = cfg_wr_data;
            if (start && !busy)
            begin
                step_results.delete();
                table_step(cmd_word);
                if (cmd_word.operation != OP_NONE)
                    n_words++;
                if (cur_typed)
                    due_results.push_back(cur_want);
                else
                begin
                    foreach (step_results[k])
                        due_results.push_back(step_results[k]);
                end
            end
            if (res_valid)
                check_result(res_word);
        end
    end

    // Hands one command word over, then keeps to the burst pattern
    task automatic drive_word(input cmd_t w, input logic typed, input result_t want);
        int gap;
        start     <= 1'b1;
        cmd_word  <= w;
        cur_typed <= typed;
        cur_want  <= want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Retry limit write with the block idle: nothing due and any scan run out
    task automatic write_limit(input logic [7:0] v);
        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic row_plain(input cmd_t w);
        stim_row_t r;
        r.is_cfg  = 1'b0;
        r.cfg_val = '0;
        r.word    = w;
        r.typed   = 1'b0;
        r.want    = '0;
        directed_rows.push_back(r);
    endtask

    task automatic row_typed(input cmd_t w, input result_t want);
        stim_row_t r;
        r.is_cfg  = 1'b0;
        r.cfg_val = '0;
        r.word    = w;
        r.typed   = 1'b1;
        r.want    = want;
        directed_rows.push_back(r);
    endtask

    task automatic row_cfg(input logic [7:0] v);
        stim_row_t r;
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        r.word    = '0;
        r.typed   = 1'b0;
        r.want    = '0;
        directed_rows.push_back(r);
    endtask

    task automatic build_directed();
        // After reset, limit 3: empty tick, unmatched ack
        row_typed(mk_cmd(OP_TICK, 8'hFF, 11'h7FF),
                  mk_res(KIND_DONE, 1'b0, 0, 8'd0, 11'd0, 8'd0, 4'd0, 1'b1));
        row_typed(mk_cmd(OP_ACK, 8'h00, 11'd0),
                  mk_res(KIND_ACK, 1'b0, 0, 8'h00, 11'd0, 8'd0, 4'd0, 1'b1));
        // Length and segment extremes
        row_typed(mk_cmd(OP_ADD, 8'h00, 11'd0),
                  mk_res(KIND_ADD, 1'b1, 0, 8'h00, 11'd0, 8'd0, 4'd1, 1'b1));
        row_typed(mk_cmd(OP_ADD, 8'hFF, 11'd1024),
                  mk_res(KIND_ADD, 1'b1, 1, 8'hFF, 11'd1024, 8'd0, 4'd2, 1'b1));
        // Oversize adds refused like a full table
        row_typed(mk_cmd(OP_ADD, 8'h5A, 11'd1025),
                  mk_res(KIND_ADD, 1'b0, 0, 8'h5A, 11'd0, 8'd0, 4'd2, 1'b1));
        row_typed(mk_cmd(OP_ADD, 8'hA5, 11'h7FF),
                  mk_res(KIND_ADD, 1'b0, 0, 8'hA5, 11'd0, 8'd0, 4'd2, 1'b1));
        // Unused code: taken, nothing back
        row_plain(mk_cmd(OP_NONE, 8'hFF, 11'h7FF));
        // Two entries of one segment, cleared by a single ack
        row_typed(mk_cmd(OP_ADD, 8'h5A, 11'd100),
                  mk_res(KIND_ADD, 1'b1, 2, 8'h5A, 11'd100, 8'd0, 4'd3, 1'b1));
        row_typed(mk_cmd(OP_ADD, 8'h5A, 11'd200),
                  mk_res(KIND_ADD, 1'b1, 3, 8'h5A, 11'd200, 8'd0, 4'd4, 1'b1));
        row_typed(mk_cmd(OP_ACK, 8'h5A, 11'h7FF),
                  mk_res(KIND_ACK, 1'b1, 2, 8'h5A, 11'd0, 8'd0, 4'd2, 1'b1));
        row_plain(mk_cmd(OP_TICK, 8'h00, 11'd0));
        // Limit dropped under pending entries: attempt number wraps
        row_cfg(8'd0);
        row_plain(mk_cmd(OP_TICK, 8'h00, 11'd0));
        row_plain(mk_cmd(OP_TICK, 8'h00, 11'd0));
        row_plain(mk_cmd(OP_TICK, 8'h00, 11'd0));   // both entries given up
        // Fill every slot, then one more
        for (int i = 0; i < QUEUE_DEPTH; i++)
            row_typed(mk_cmd(OP_ADD, 8'(1 << i), 11'(i * 100 + 3)),
                      mk_res(KIND_ADD, 1'b1, i, 8'(1 << i), 11'(i * 100 + 3), 8'd0,
                             4'(i + 1), 1'b1));
        row_typed(mk_cmd(OP_ADD, 8'h33, 11'd64),
                  mk_res(KIND_ADD, 1'b0, 0, 8'h33, 11'd0, 8'd0, 4'd8, 1'b1));
        row_plain(mk_cmd(OP_TICK, 8'h00, 11'd0));   // limit 0: whole table given up
    endtask

    // Mostly adds and acks of live segments, the odd tick, a little noise
    task automatic pick_word(output cmd_t w);
        int r;
        int n;
        logic [7:0] live [$];
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (shadow_pending[i])
                live.push_back(shadow_seg[i]);
        end
        r = $urandom_range(0, 99);
        w.segment_number = 8'($urandom_range(0, 255));
        w.packet_length  = 11'($urandom_range(0, MAX_PACKET_BYTES));
        if (r < 45)
        begin
            w.operation = OP_ADD;
            n = $urandom_range(0, 99);
            if (n < 8)
                w.packet_length = 11'($urandom_range(MAX_PACKET_BYTES + 1, 2047));
            else if (n < 12)
                w.packet_length = 11'd0;
            else if (n < 16)
                w.packet_length = 11'(MAX_PACKET_BYTES);
            // reuse a live segment now and then so an ack clears several
            if (live.size() != 0 && $urandom_range(0, 3) == 0)
                w.segment_number = live[$urandom_range(0, live.size() - 1)];
        end
        else if (r < 76)
        begin
            w.operation = OP_ACK;
            if (live.size() != 0 && $urandom_range(0, 9) < 7)
                w.segment_number = live[$urandom_range(0, live.size() - 1)];
        end
        else if (r < 93)
            w.operation = OP_TICK;
        else
        begin
            w.operation     = OP_NONE;
            w.packet_length = 11'($urandom_range(0, 2047));
        end
    endtask

    initial
    begin
        cmd_t w;
        logic [7:0] phase_limit [4];
        int cnt;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd_word    = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        cur_typed   = 1'b0;
        cur_want    = '0;
        err_count   = 0;
        cycle_count = 0;
        n_words     = 0;
        n_refused   = 0;
        n_ticks     = 0;
        n_retx      = 0;
        n_giveup    = 0;
        n_checked   = 0;
        burst_left  = $urandom_range(1, 20);
        shadow_reset();
        build_directed();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed table
        foreach (directed_rows[k])
        begin
            if (directed_rows[k].is_cfg)
                write_limit(directed_rows[k].cfg_val);
            else
                drive_word(directed_rows[k].word, directed_rows[k].typed,
                           directed_rows[k].want);
        end

        // Random phases over several retry limits, extremes included
        mid_limit      = 8'($urandom_range(2, 254));
        phase_limit[0] = 8'd255;
        phase_limit[1] = 8'd1;
        phase_limit[2] = mid_limit;
        phase_limit[3] = 8'd0;
        for (int p = 0; p < 4; p++)
        begin
            write_limit(phase_limit[p]);
            cnt = 0;
            while (cnt < PHASE_WORDS)
            begin
                pick_word(w);
                drive_word(w, 1'b0, '0);
                if (w.operation != OP_NONE)
                    cnt++;
            end
        end

        // Drain
        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (due_results.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived", due_results.size()));

        $display("Ran %0d command words: %0d adds refused, %0d ticks, %0d retransmits, %0d give-ups",
                 n_words, n_refused, n_ticks, n_retx, n_giveup);
        $display("Retry limit taken through 3, 0, 255, 1, %0d and 0; %0d result words compared",
                 mid_limit, n_checked);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
rtl/rtt_pkg.sv
rtl/rtt_front.sv
rtl/rtt_back.sv
rtl/retransmission_tracking_table_core.sv
rtl/rtt_checker.sv
sim/retransmission_tracking_table_core_tb.sv
